FILE: src/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and fixed widths for the triangle circumcentre block.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int OUT_W = 48;   // centre coordinate width
    localparam int THR_W = 40;   // degenerate threshold width

    // control bits that ride along the divider row
    typedef struct packed {
        logic valid;
        logic deg;
        logic neg_x;
        logic neg_y;
    } tcc_ctl_t;

endpackage
`default_nettype wire

FILE: src/tcc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_front
// Five-stage arithmetic front end: differences, products, determinant,
// numerators, then magnitude and divisor set-up for the divider row.
// ----------------------------------------------------------------------------
module tcc_front
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      en,
    input  wire logic                                      in_valid,
    input  wire logic [COORD_BITS-1:0]                     ax,
    input  wire logic [COORD_BITS-1:0]                     ay,
    input  wire logic [COORD_BITS-1:0]                     bx,
    input  wire logic [COORD_BITS-1:0]                     by_coord,
    input  wire logic [COORD_BITS-1:0]                     qx,
    input  wire logic [COORD_BITS-1:0]                     qy,
    input  wire logic [THR_W-1:0]                          thr,
    output tcc_ctl_t                                       ctl,
    output logic [2*COORD_BITS+3:0]                        den,
    output logic [(2*COORD_BITS+4)+(3*COORD_BITS+5+FRAC_BITS)-1:0] acc_x,
    output logic [(2*COORD_BITS+4)+(3*COORD_BITS+5+FRAC_BITS)-1:0] acc_y
);

    localparam int C    = COORD_BITS;
    localparam int P2   = 2*C + 2;
    localparam int P3   = 2*C + 3;
    localparam int P4   = 3*C + 4;
    localparam int NW   = 3*C + 5;
    localparam int DW   = 2*C + 4;
    localparam int UW   = NW + FRAC_BITS;
    localparam int CMPW = (P3 > THR_W) ? P3 : THR_W;

    // stage 1
    logic               v1_reg;
    logic signed [C:0]  d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic signed [C:0]  sax_reg, say_reg, sbx_reg, sby_reg;
    logic signed [C-1:0] ax1_reg, ay1_reg;
    // stage 2
    logic               v2_reg;
    logic signed [P2-1:0] pda_reg, pdb_reg, p1a_reg, p1b_reg, p2a_reg, p2b_reg;
    logic signed [C:0]  d1x2_reg, d1y2_reg, d2x2_reg, d2y2_reg;
    logic signed [C-1:0] ax2_reg, ay2_reg;
    // stage 3
    logic               v3_reg;
    logic signed [P3-1:0] det3_reg, s1_reg, s2_reg;
    logic signed [C:0]  d1x3_reg, d1y3_reg, d2x3_reg, d2y3_reg;
    logic signed [C-1:0] ax3_reg, ay3_reg;
    // stage 4
    logic               v4_reg, deg4_reg, dneg4_reg;
    logic [P3-1:0]      dmag4_reg;
    logic signed [P4-1:0] mx1_reg, mx2_reg, my1_reg, my2_reg;
    logic signed [C-1:0] ax4_reg, ay4_reg;
    // stage 5 outputs
    tcc_ctl_t           ctl_reg;
    logic [DW-1:0]      den_reg;
    logic [DW+UW-1:0]   accx_reg, accy_reg;

    logic [P3-1:0]        dmag3;
    logic                 deg3;
    logic signed [NW-1:0] nx5, ny5;
    logic [NW-1:0]        magx5, magy5;

    always_comb
    begin
        dmag3 = det3_reg[P3-1] ? P3'(-det3_reg) : P3'(det3_reg);
        deg3  = (CMPW'(dmag3) < CMPW'(thr)) || (dmag3 == '0);
        nx5   = deg4_reg ? NW'(ax4_reg) : (NW'(mx1_reg) - NW'(mx2_reg));
        ny5   = deg4_reg ? NW'(ay4_reg) : (NW'(my1_reg) - NW'(my2_reg));
        magx5 = nx5[NW-1] ? NW'(-nx5) : NW'(nx5);
        magy5 = ny5[NW-1] ? NW'(-ny5) : NW'(ny5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            ctl_reg.valid <= v4_reg;
            ctl_reg.deg   <= deg4_reg;
            ctl_reg.neg_x <= nx5[NW-1] ^ (dneg4_reg & ~deg4_reg);
            ctl_reg.neg_y <= ny5[NW-1] ^ (dneg4_reg & ~deg4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg  <= $signed({ax[C-1], ax}) - $signed({qx[C-1], qx});
            d1y_reg  <= $signed({ay[C-1], ay}) - $signed({qy[C-1], qy});
            d2x_reg  <= $signed({bx[C-1], bx}) - $signed({qx[C-1], qx});
            d2y_reg  <= $signed({by_coord[C-1], by_coord}) - $signed({qy[C-1], qy});
            sax_reg  <= $signed({ax[C-1], ax}) + $signed({qx[C-1], qx});
            say_reg  <= $signed({ay[C-1], ay}) + $signed({qy[C-1], qy});
            sbx_reg  <= $signed({bx[C-1], bx}) + $signed({qx[C-1], qx});
            sby_reg  <= $signed({by_coord[C-1], by_coord}) + $signed({qy[C-1], qy});
            ax1_reg  <= $signed(ax);
            ay1_reg  <= $signed(ay);

            pda_reg  <= P2'(d1x_reg) * P2'(d2y_reg);
            pdb_reg  <= P2'(d2x_reg) * P2'(d1y_reg);
            p1a_reg  <= P2'(d1x_reg) * P2'(sax_reg);
            p1b_reg  <= P2'(d1y_reg) * P2'(say_reg);
            p2a_reg  <= P2'(d2x_reg) * P2'(sbx_reg);
            p2b_reg  <= P2'(d2y_reg) * P2'(sby_reg);
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            d2x2_reg <= d2x_reg;
            d2y2_reg <= d2y_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;

            det3_reg <= P3'(pda_reg) - P3'(pdb_reg);
            s1_reg   <= P3'(p1a_reg) + P3'(p1b_reg);
            s2_reg   <= P3'(p2a_reg) + P3'(p2b_reg);
            d1x3_reg <= d1x2_reg;
            d1y3_reg <= d1y2_reg;
            d2x3_reg <= d2x2_reg;
            d2y3_reg <= d2y2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;

            mx1_reg   <= P4'(s1_reg) * P4'(d2y3_reg);
            mx2_reg   <= P4'(s2_reg) * P4'(d1y3_reg);
            my1_reg   <= P4'(s2_reg) * P4'(d1x3_reg);
            my2_reg   <= P4'(s1_reg) * P4'(d2x3_reg);
            dmag4_reg <= dmag3;
            deg4_reg  <= deg3;
            dneg4_reg <= det3_reg[P3-1];
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;

            // degenerate: divide the first vertex by one, giving ax << FRAC_BITS
            den_reg  <= deg4_reg ? DW'(1) : DW'({dmag4_reg, 1'b0});
            accx_reg <= {{DW{1'b0}}, UW'(magx5) << FRAC_BITS};
            accy_reg <= {{DW{1'b0}}, UW'(magy5) << FRAC_BITS};
        end
    end

    assign ctl   = ctl_reg;
    assign den   = den_reg;
    assign acc_x = accx_reg;
    assign acc_y = accy_reg;

endmodule
`default_nettype wire

FILE: src/tcc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_div_cell
// One restoring division step for both coordinates sharing one divisor.
// ----------------------------------------------------------------------------
module tcc_div_cell
    import tcc_pkg::*;
#(
    parameter int DW = 36,
    parameter int UW = 69
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire tcc_ctl_t        ctl_in,
    input  wire logic [DW-1:0]   den_in,
    input  wire logic [DW+UW-1:0] accx_in,
    input  wire logic [DW+UW-1:0] accy_in,
    output tcc_ctl_t             ctl_out,
    output logic [DW-1:0]        den_out,
    output logic [DW+UW-1:0]     accx_out,
    output logic [DW+UW-1:0]     accy_out
);

    localparam int AW = DW + UW;

    tcc_ctl_t          ctl_reg;
    logic [DW-1:0]     den_reg;
    logic [AW-1:0]     accx_reg, accy_reg;
    logic [AW-1:0]     accx_next, accy_next;

    logic [DW:0] tx, ty, sx, sy;
    logic        gex, gey;

    always_comb
    begin
        // bring down the next dividend bit, trial subtract
        tx  = {accx_in[AW-1:UW], accx_in[UW-1]};
        ty  = {accy_in[AW-1:UW], accy_in[UW-1]};
        sx  = tx - {1'b0, den_in};
        sy  = ty - {1'b0, den_in};
        gex = tx >= {1'b0, den_in};
        gey = ty >= {1'b0, den_in};
        accx_next = {gex ? sx[DW-1:0] : tx[DW-1:0], accx_in[UW-2:0], gex};
        accy_next = {gey ? sy[DW-1:0] : ty[DW-1:0], accy_in[UW-2:0], gey};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            accx_reg <= accx_next;
            accy_reg <= accy_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign den_out  = den_reg;
    assign accx_out = accx_reg;
    assign accy_out = accy_reg;

endmodule
`default_nettype wire

FILE: src/tcc_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_out
// Sign restore, 48-bit saturation and the output register.
// ----------------------------------------------------------------------------
module tcc_out
    import tcc_pkg::*;
#(
    parameter int UW = 69
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire tcc_ctl_t         ctl,
    input  wire logic [UW-1:0]    qx,
    input  wire logic [UW-1:0]    qy,
    output logic                  out_valid,
    output logic [OUT_W-1:0]      center_x,
    output logic [OUT_W-1:0]      center_y,
    output logic                  degenerate,
    output logic                  saturated
);

    localparam int QE = UW + OUT_W;

    logic             valid_reg;
    logic [OUT_W-1:0] cx_reg, cy_reg;
    logic             deg_reg, sat_reg;
    logic [OUT_W-1:0] vx, vy;
    logic             satx, saty;

    function automatic logic [OUT_W:0] clip(input logic neg_in, input logic [UW-1:0] q);
        logic [QE-1:0]    qe;
        logic [QE-1:0]    maxp;
        logic [QE-1:0]    maxn;
        logic             neg;
        logic [OUT_W-1:0] v;
        logic             s;
        qe   = QE'(q);
        maxp = (QE'(1) << (OUT_W - 1)) - QE'(1);
        maxn = QE'(1) << (OUT_W - 1);
        neg  = neg_in && (q != '0);
        s    = neg ? (qe > maxn) : (qe > maxp);
        if (!neg)
        begin
            v = s ? maxp[OUT_W-1:0] : qe[OUT_W-1:0];
        end
        else
        begin
            v = s ? maxn[OUT_W-1:0] : OUT_W'(-qe[OUT_W-1:0]);
        end
        return {s, v};
    endfunction

    always_comb
    begin
        {satx, vx} = clip(ctl.neg_x, qx);
        {saty, vy} = clip(ctl.neg_y, qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg  <= vx;
            cy_reg  <= vy;
            deg_reg <= ctl.deg;
            sat_reg <= satx | saty;
        end
    end

    assign out_valid  = valid_reg;
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

endmodule
`default_nettype wire

FILE: src/triangle_circumcenter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_circumcenter
// Circumcentre of a 2D integer triangle in signed fixed point, with a
// degenerate-triangle threshold and 48-bit saturation.
// ----------------------------------------------------------------------------
//  channel  | dir | contents (lowest bits first)
//  s_axis   | in  | tdata: ax, ay, bx, by_coord, qx, qy (COORD_BITS each)
//  m_axis   | out | tdata: center_x, center_y (48 each); tuser: degenerate, saturated
//  cfg      | in  | cfg_we / cfg_wdata: degenerate threshold (40 bits)
//
//  One request per clock sustained. Requests pass the front end, the divider row
//  (a cell per quotient bit, UW = 3*COORD_BITS+5+FRAC_BITS) and the output register.
//  The whole pipe advances together; it holds only while a finished result
//  sits in the output register and the sink is not ready.
//  Reset clears valid flags and loads the threshold with 1 (zero det only).
// ----------------------------------------------------------------------------
module triangle_circumcenter
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // ax, ay, bx, by_coord, qx, qy
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // center_x, center_y
    output logic [2*OUT_W-1:0]                       m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]                               m_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                cfg_we,
    input  wire logic [THR_W-1:0]                    cfg_wdata
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2*C + 4;               // divisor width (2|D|)
    localparam int UW = 3*C + 5 + FRAC_BITS;   // scaled dividend / quotient width
    localparam int AW = DW + UW;

    logic             en;
    logic [THR_W-1:0] thr_reg;

    // divider row links: index 0 from the front end, UW into the output stage
    tcc_ctl_t      c_ctl  [0:UW];
    logic [DW-1:0] c_den  [0:UW];
    logic [AW-1:0] c_accx [0:UW];
    logic [AW-1:0] c_accy [0:UW];

    logic [OUT_W-1:0] cx, cy;
    logic             deg, sat;

    // pipe moves unless the output register is full and stalled
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    tcc_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .ax       (s_axis_tdata[C-1:0]),
        .ay       (s_axis_tdata[2*C-1:C]),
        .bx       (s_axis_tdata[3*C-1:2*C]),
        .by_coord (s_axis_tdata[4*C-1:3*C]),
        .qx       (s_axis_tdata[5*C-1:4*C]),
        .qy       (s_axis_tdata[6*C-1:5*C]),
        .thr      (thr_reg),
        .ctl      (c_ctl[0]),
        .den      (c_den[0]),
        .acc_x    (c_accx[0]),
        .acc_y    (c_accy[0])
    );

    // one quotient bit per cell, most significant first
    for (genvar i = 0; i < UW; i++)
    begin : g_cell
        tcc_div_cell #(
            .DW (DW),
            .UW (UW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (c_ctl[i]),
            .den_in   (c_den[i]),
            .accx_in  (c_accx[i]),
            .accy_in  (c_accy[i]),
            .ctl_out  (c_ctl[i+1]),
            .den_out  (c_den[i+1]),
            .accx_out (c_accx[i+1]),
            .accy_out (c_accy[i+1])
        );
    end

    tcc_out #(
        .UW (UW)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl        (c_ctl[UW]),
        .qx         (c_accx[UW][UW-1:0]),
        .qy         (c_accy[UW][UW-1:0]),
        .out_valid  (m_axis_tvalid),
        .center_x   (cx),
        .center_y   (cy),
        .degenerate (deg),
        .saturated  (sat)
    );

    assign m_axis_tdata = {cy, cx};
    assign m_axis_tuser = {sat, deg};

`ifndef SYNTHESIS
    // last cell's valid request lands in the output register
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        c_ctl[UW].valid && en |=> m_axis_tvalid)
        else $error("request lost between divider row and output");

    // a clipped result must sit on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[OUT_W-1:0] == {1'b0, {(OUT_W-1){1'b1}}}) ||
            (m_axis_tdata[OUT_W-1:0] == {1'b1, {(OUT_W-1){1'b0}}}) ||
            (m_axis_tdata[2*OUT_W-1:OUT_W] == {1'b0, {(OUT_W-1){1'b1}}}) ||
            (m_axis_tdata[2*OUT_W-1:OUT_W] == {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("saturated flag without rail value");

    // unclipped degenerate center_x is the vertex shifted up: no fraction bits
    a_deg_frac: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] |->
            ((m_axis_tdata[OUT_W-1:0] & ((OUT_W'(1) << FRAC_BITS) - OUT_W'(1))) == '0))
        else $error("degenerate result carries fraction bits");

    // row holds while stalled
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(c_ctl[UW]))
        else $error("divider row moved during stall");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_triangle_circumcenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_circumcenter
// Self-checking bench for the circumcentre block: directed corner triangles,
// then random ones under several threshold settings, with random stalls on
// both streams. Results are predicted in wide integers and checked in order.
// ----------------------------------------------------------------------------
module tb_triangle_circumcenter;
    import tcc_pkg::*;

    localparam int CB   = 16;
    localparam int FB   = 16;
    localparam int IN_W = ((6*CB+7)/8)*8;
    localparam int LAT  = 5 + 3*CB + 5 + FB + 1;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [OUT_W-1:0] cy;
        logic [OUT_W-1:0] cx;
        logic             deg;
        logic             sat;
    } centre_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the centre of each accepted request and checks the
    // returned results against them in order.
    // ------------------------------------------------------------------------
    class centre_board;
        centre_t         pending[$];
        logic [THR_W-1:0] thresh;
        int              errors;

        function new();
            thresh = 1;
            errors = 0;
        endfunction

        // clip a 160-bit signed value to 48 bits
        function logic [OUT_W-1:0] clip(logic signed [159:0] v, inout logic sat);
            logic signed [159:0] hi;
            logic signed [159:0] lo;
            hi = (160'sd1 <<< (OUT_W-1)) - 1;
            lo = -(160'sd1 <<< (OUT_W-1));
            if (v > hi)
            begin
                sat = 1'b1;
                return hi[OUT_W-1:0];
            end
            if (v < lo)
            begin
                sat = 1'b1;
                return lo[OUT_W-1:0];
            end
            return v[OUT_W-1:0];
        endfunction

        // quotient truncated toward zero
        function logic signed [159:0] tdiv(logic signed [159:0] n, logic signed [159:0] d);
            logic signed [159:0] an;
            logic signed [159:0] ad;
            logic signed [159:0] q;
            an = n < 0 ? -n : n;
            ad = d < 0 ? -d : d;
            q = an / ad;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function void note_request(logic [IN_W-1:0] data);
            logic signed [159:0] ax, ay, bx, by, qx, qy, d1x, d1y, d2x, d2y;
            logic signed [159:0] det, dmag, s1, s2, nx, ny;
            centre_t r;
            ax = $signed(data[0*CB +: CB]);
            ay = $signed(data[1*CB +: CB]);
            bx = $signed(data[2*CB +: CB]);
            by = $signed(data[3*CB +: CB]);
            qx = $signed(data[4*CB +: CB]);
            qy = $signed(data[5*CB +: CB]);
            d1x = ax - qx; d1y = ay - qy; d2x = bx - qx; d2y = by - qy;
            det = d1x*d2y - d2x*d1y;
            dmag = det < 0 ? -det : det;
            r.sat = 1'b0;
            if (dmag < $signed({120'd0, thresh}) || dmag == 0)
            begin
                r.deg = 1'b1;
                r.cx = clip(ax <<< FB, r.sat);
                r.cy = clip(ay <<< FB, r.sat);
            end
            else
            begin
                s1 = d1x*(ax+qx) + d1y*(ay+qy);
                s2 = d2x*(bx+qx) + d2y*(by+qy);
                nx = s1*d2y - s2*d1y;
                ny = s2*d1x - s1*d2x;
                r.deg = 1'b0;
                r.cx = clip(tdiv(nx <<< FB, 2*det), r.sat);
                r.cy = clip(tdiv(ny <<< FB, 2*det), r.sat);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [2*OUT_W-1:0] data, logic [1:0] user);
            centre_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[OUT_W-1:0] !== e.cx)
            begin
                $error("center_x exp %h got %h", e.cx, data[OUT_W-1:0]);
                errors++;
            end
            if (data[2*OUT_W-1:OUT_W] !== e.cy)
            begin
                $error("center_y exp %h got %h", e.cy, data[2*OUT_W-1:OUT_W]);
                errors++;
            end
            if (user[0] !== e.deg)
            begin
                $error("degenerate exp %b got %b", e.deg, user[0]);
                errors++;
            end
            if (user[1] !== e.sat)
            begin
                $error("saturated exp %b got %b", e.sat, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [2*OUT_W-1:0]     m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   cfg_we;
    logic [THR_W-1:0]       cfg_wdata;

    centre_board board;
    bit          calm;        // no idling on either side while set
    int          idle_cnt;    // cycles with nothing accepted

    triangle_circumcenter #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink: random back-pressure, results checked at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // watchdog on the handshakes
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else if (rst_n)
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WATCHDOG)
        begin
            $display("tb_triangle_circumcenter: done, errors");
            $finish;
        end
    end

    // one request; a random gap first unless calm
    task automatic send_tri(input logic signed [CB-1:0] ax, ay, bx, by, qx, qy);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {qy, qx, by, bx, ay, ax};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(s_axis_tdata);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.thresh = v;
    endtask

    // random triangle; half small spans so thresholds bite, half full range
    task automatic send_random();
        logic signed [CB-1:0] c[6];
        int span;
        case ($urandom_range(3))
            0: span = 8;
            1: span = 300;
            default: span = 0;
        endcase
        foreach (c[i])
            c[i] = span == 0 ? CB'($urandom) : CB'($urandom_range(2*span) - span);
        if ($urandom_range(9) == 0)
        begin
            // collinear: B on the line through Q and A
            c[2] = c[4] + 2*(c[0] - c[4]);
            c[3] = c[5] + 2*(c[1] - c[5]);
        end
        send_tri(c[0], c[1], c[2], c[3], c[4], c[5]);
    endtask

    localparam logic signed [CB-1:0] MX = 16'sh7fff;
    localparam logic signed [CB-1:0] MN = -16'sh8000;

    initial
    begin
        logic [THR_W-1:0] thr[5];
        board = new();
        calm = 1'b0;
        idle_cnt = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset threshold, corners, degenerate and saturating cases
        send_tri(0, 0, 0, 0, 0, 0);            // all coincident
        send_tri(MX, MX, MX, MX, MX, MX);
        send_tri(MN, MN, MN, MN, MN, MN);      // degenerate, most negative corner
        send_tri(MX, MN, MX, MN, MX, MN);      // degenerate, mixed corners
        send_tri(1, 0, 0, 1, 0, 0);
        send_tri(-1, 0, 0, -1, 0, 0);
        send_tri(MX, 0, 0, MX, MN, MN);
        send_tri(MN, MX, MX, MN, 0, 0);        // near-collinear, extremes
        send_tri(MX, MX, MN, MX, MN, MN);
        send_tri(1, 0, MX, 1, 0, 0);           // thin: huge centre
        send_tri(-1, 0, MN, -1, 0, 0);
        send_tri(2, 0, 4, 1, 0, 0);
        send_tri(-16'sh5555, 16'sh2aaa, 16'sh5555, -16'sh2aaa, 3, -3);
        drain();

        write_threshold(0);                    // zero threshold, zero det
        send_tri(5, 5, 5, 5, 5, 5);
        send_tri(1, 0, 0, 1, 0, 0);
        drain();
        write_threshold({THR_W{1'b1}});        // everything degenerate
        send_tri(MX, MN, 0, 0, MN, MX);
        send_tri(MN, MX, 1, 2, 3, 4);
        drain();

        thr = '{1, 0, 50, 3000, {THR_W{1'b1}}};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(ph == 2 ? THR_W'($urandom_range(200)) : thr[ph]);
            for (int i = 0; i < 340; i++)
            begin
                calm = (ph == 1 && i >= 100 && i < 250);
                send_random();
            end
            calm = 1'b0;
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_triangle_circumcenter: done, clean");
        else
            $display("tb_triangle_circumcenter: done, errors");
        $finish;
    end
endmodule
